>>> rtl/sst_pkg.sv
// Shared constants, codes and controller/datapath bundles for the sorted slot table.
package sst_pkg;

  // Table geometry
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int KEY_W    = 14;

  // Field widths
  localparam int OP_W     = 2;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int STATUS_W = 3;

  // Range limits
  localparam logic [MONTH_W-1:0] MONTH_MAX = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_MAX   = DAY_W'(31);
  localparam logic [HOUR_W-1:0]  HOUR_MAX  = HOUR_W'(23);

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_MONTH = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_DAY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_HOUR  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd7;

  // Index counter operations
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT
  } idx_op_t;

  // Read address selection relative to the index
  typedef enum logic [1:0] {
    RD_IDX,
    RD_DEC,
    RD_INC
  } rd_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic                capture;
    idx_op_t             idx_op;
    logic                pos_load;
    logic                ram_re;
    rd_sel_t             rd_sel;
    logic                ram_we;
    logic                wr_key;
    logic                count_inc;
    logic                count_dec;
    logic                res_load;
    logic [STATUS_W-1:0] res_code;
    logic                out_load;
    logic                out_entry;
  } sst_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [STATUS_W-1:0] range_st;
    logic                count_zero;
    logic                count_full;
    logic                idx_at_count;
    logic                idx_at_pos;
    logic                idx_next_last;
    logic                cmp_lt;
    logic                cmp_eq;
    logic                out_free;
  } sst_stat_t;

endpackage

>>> rtl/sst_in_if.sv
// Request channel: operation and slot key words.
interface sst_in_if;
  import sst_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [MONTH_W-1:0] slot_month;
  logic [DAY_W-1:0]   slot_day;
  logic [HOUR_W-1:0]  slot_hour;

  modport source (output valid, output operation, output slot_month, output slot_day,
                  output slot_hour, input ready);
  modport sink (input valid, input operation, input slot_month, input slot_day,
                input slot_hour, output ready);
endinterface

>>> rtl/sst_out_if.sv
// Response channel: status and listed entry words.
interface sst_out_if;
  import sst_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                entry_valid;
  logic [MONTH_W-1:0]  entry_month;
  logic [DAY_W-1:0]    entry_day;
  logic [HOUR_W-1:0]   entry_hour;
  logic                last;

  modport source (output valid, output status, output entry_valid, output entry_month,
                  output entry_day, output entry_hour, output last, input ready);
  modport sink (input valid, input status, input entry_valid, input entry_month,
                input entry_day, input entry_hour, input last, output ready);
endinterface

>>> rtl/sorted_slot_table.sv
// Top level of the sorted slot table: controller, datapath and channel wiring.
//
//   channel | dir | modport | word
//   req     | in  | sink    | operation, slot_month, slot_day, slot_hour
//   rsp     | out | source  | status, entry_valid, entry_month/day/hour, last
//
// Insert/delete: a check step, then a read and a compare step per entry scanned
// and a read and a write step per entry shifted, then the result is posted; the
// entries scanned and shifted together number at most the count plus one. Each
// entry needs a read step and then a step to use it, set by the key store's single
// read port and registered read. List: a read, then an emit step per stored key.
// Reset clears the entry count and the controller; the store needs no clearing.
// A stalled rsp holds the controller in its emit step; req is taken only when idle,
// which may be while the last response word still waits in the output register.
module sorted_slot_table (
  input logic      clk,
  input logic      rst,
  sst_in_if.sink   req,
  sst_out_if.source rsp
);
  import sst_pkg::*;

  sst_cmd_t  cmd;
  sst_stat_t stat;

  sst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (req.valid),
    .ready (req.ready),
    .stat  (stat),
    .cmd   (cmd)
  );

  sst_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (req.operation),
    .in_month        (req.slot_month),
    .in_day          (req.slot_day),
    .in_hour         (req.slot_hour),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_entry_valid (rsp.entry_valid),
    .out_month       (rsp.entry_month),
    .out_day         (rsp.entry_day),
    .out_hour        (rsp.entry_hour),
    .out_last        (rsp.last)
  );

endmodule

>>> rtl/sst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sst_dp.sv
// Datapath: key store, entry count, index and position, output register.
module sst_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  sst_pkg::sst_cmd_t         cmd,
  output sst_pkg::sst_stat_t        stat,
  input  logic [sst_pkg::OP_W-1:0]    in_operation,
  input  logic [sst_pkg::MONTH_W-1:0] in_month,
  input  logic [sst_pkg::DAY_W-1:0]   in_day,
  input  logic [sst_pkg::HOUR_W-1:0]  in_hour,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sst_pkg::STATUS_W-1:0] out_status,
  output logic                        out_entry_valid,
  output logic [sst_pkg::MONTH_W-1:0] out_month,
  output logic [sst_pkg::DAY_W-1:0]   out_day,
  output logic [sst_pkg::HOUR_W-1:0]  out_hour,
  output logic                        out_last
);
  import sst_pkg::*;

  logic [OP_W-1:0]     op;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [KEY_W-1:0]    key;
  logic [IDX_W-1:0]    count;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    idx_next;
  logic [IDX_W-1:0]    pos;
  logic [STATUS_W-1:0] res_code;
  logic [IDX_W-1:0]    rd_idx;
  logic [KEY_W-1:0]    ram_q;
  logic [KEY_W-1:0]    wdata;
  logic                out_free;
  logic [STATUS_W-1:0] range_st;

  assign key = {month, day, hour};

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= in_operation;
      month <= in_month;
      day   <= in_day;
      hour  <= in_hour;
    end
  end

  // Advance the index counter
  always_comb begin
    unique case (cmd.idx_op)
      IDX_HOLD:  idx_next = idx;
      IDX_ZERO:  idx_next = '0;
      IDX_INC:   idx_next = idx + IDX_W'(1);
      IDX_DEC:   idx_next = idx - IDX_W'(1);
      IDX_COUNT: idx_next = count;
      default:   idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else begin
      idx <= idx_next;
      if (cmd.count_inc) begin
        count <= count + IDX_W'(1);
      end else if (cmd.count_dec) begin
        count <= count - IDX_W'(1);
      end
    end
  end

  // Hold insert position and pending result code
  always_ff @(posedge clk) begin
    if (cmd.pos_load) begin
      pos <= idx;
    end
    if (cmd.res_load) begin
      res_code <= cmd.res_code;
    end
  end

  // Key store
  always_comb begin
    unique case (cmd.rd_sel)
      RD_IDX:  rd_idx = idx;
      RD_DEC:  rd_idx = idx - IDX_W'(1);
      RD_INC:  rd_idx = idx + IDX_W'(1);
      default: rd_idx = idx;
    endcase
  end

  assign wdata = cmd.wr_key ? key : ram_q;

  sst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (idx[ADDR_W-1:0]),
    .wdata (wdata),
    .re    (cmd.ram_re),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  // Range check in month, day, hour order
  always_comb begin
    priority if (month < MONTH_W'(1) || month > MONTH_MAX) begin
      range_st = ST_BAD_MONTH;
    end else if (day < DAY_W'(1) || day > DAY_MAX) begin
      range_st = ST_BAD_DAY;
    end else if (hour > HOUR_MAX) begin
      range_st = ST_BAD_HOUR;
    end else begin
      range_st = ST_OK;
    end
  end

  assign out_free           = !out_valid || out_ready;
  assign stat.op            = op;
  assign stat.range_st      = range_st;
  assign stat.count_zero    = (count == '0);
  assign stat.count_full    = (count == IDX_W'(CAPACITY));
  assign stat.idx_at_count  = (idx == count);
  assign stat.idx_at_pos    = (idx == pos);
  assign stat.idx_next_last = ((idx + IDX_W'(1)) == count);
  assign stat.cmp_lt        = (ram_q < key);
  assign stat.cmp_eq        = (ram_q == key);
  assign stat.out_free      = out_free;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_entry) begin
        out_status      <= ST_OK;
        out_entry_valid <= 1'b1;
        out_month       <= ram_q[KEY_W-1 -: MONTH_W];
        out_day         <= ram_q[HOUR_W +: DAY_W];
        out_hour        <= ram_q[HOUR_W-1:0];
        out_last        <= stat.idx_next_last;
      end else begin
        out_status      <= res_code;
        out_entry_valid <= 1'b0;
        out_month       <= '0;
        out_day         <= '0;
        out_hour        <= '0;
        out_last        <= 1'b1;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= IDX_W'(CAPACITY))
    else $error("entry count above capacity");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= count)
    else $error("index beyond entry count");

  a_out_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output word overwritten while pending");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.count_inc || cmd.count_dec) |-> !(cmd.count_inc && cmd.count_dec))
    else $error("count raised and lowered together");

endmodule

>>> rtl/sst_ctrl.sv
// Controller: sequences range check, scan, shift and list steps.
module sst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  sst_pkg::sst_stat_t stat,
  output sst_pkg::sst_cmd_t  cmd
);
  import sst_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_IRD   = 4'd4;
  localparam logic [3:0] S_IWR   = 4'd5;
  localparam logic [3:0] S_IKEY  = 4'd6;
  localparam logic [3:0] S_DRD   = 4'd7;
  localparam logic [3:0] S_DWR   = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;
  localparam logic [3:0] S_LRD   = 4'd10;
  localparam logic [3:0] S_LEM   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.idx_op    = IDX_HOLD;
    cmd.rd_sel    = RD_IDX;
    cmd.res_code  = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (valid) begin
          cmd.capture = 1'b1;
          cmd.idx_op  = IDX_ZERO;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.op == OP_NONE) begin
          state_next = S_IDLE;
        end else if (stat.op == OP_LIST) begin
          if (stat.count_zero) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_OK;
            state_next   = S_RESP;
          end else begin
            state_next = S_LRD;
          end
        end else if (stat.range_st != ST_OK) begin
          cmd.res_load = 1'b1;
          cmd.res_code = stat.range_st;
          state_next   = S_RESP;
        end else if (stat.op == OP_DELETE && stat.count_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_EMPTY;
          state_next   = S_RESP;
        end else begin
          state_next = S_SRD;
        end
      end
      // Scan for the first stored key not below the request key
      S_SRD: begin
        if (stat.idx_at_count) begin
          if (stat.op == OP_INSERT && !stat.count_full) begin
            cmd.pos_load = 1'b1;
            state_next   = S_IRD;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_code = (stat.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
            state_next   = S_RESP;
          end
        end else begin
          cmd.ram_re = 1'b1;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        priority if (stat.cmp_lt) begin
          cmd.idx_op = IDX_INC;
          state_next = S_SRD;
        end else if (stat.cmp_eq) begin
          if (stat.op == OP_INSERT) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_OCCUPIED;
            state_next   = S_RESP;
          end else begin
            state_next = S_DRD;
          end
        end else if (stat.op == OP_INSERT && !stat.count_full) begin
          cmd.pos_load = 1'b1;
          cmd.idx_op   = IDX_COUNT;
          state_next   = S_IRD;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_code = (stat.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
          state_next   = S_RESP;
        end
      end
      // Shift entries up from the top down to the insert position
      S_IRD: begin
        if (stat.idx_at_pos) begin
          state_next = S_IKEY;
        end else begin
          cmd.ram_re = 1'b1;
          cmd.rd_sel = RD_DEC;
          state_next = S_IWR;
        end
      end
      S_IWR: begin
        cmd.ram_we = 1'b1;
        cmd.idx_op = IDX_DEC;
        state_next = S_IRD;
      end
      S_IKEY: begin
        cmd.ram_we    = 1'b1;
        cmd.wr_key    = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.res_load  = 1'b1;
        cmd.res_code  = ST_OK;
        state_next    = S_RESP;
      end
      // Shift entries down over the deleted one
      S_DRD: begin
        if (stat.idx_next_last) begin
          cmd.count_dec = 1'b1;
          cmd.res_load  = 1'b1;
          cmd.res_code  = ST_OK;
          state_next    = S_RESP;
        end else begin
          cmd.ram_re = 1'b1;
          cmd.rd_sel = RD_INC;
          state_next = S_DWR;
        end
      end
      S_DWR: begin
        cmd.ram_we = 1'b1;
        cmd.idx_op = IDX_INC;
        state_next = S_DRD;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      // Emit stored keys in order
      S_LRD: begin
        cmd.ram_re = 1'b1;
        state_next = S_LEM;
      end
      S_LEM: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_entry = 1'b1;
          cmd.idx_op    = IDX_INC;
          state_next    = stat.idx_next_last ? S_IDLE : S_LRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Checks
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_we |-> !cmd.ram_re)
    else $error("store read and write in one cycle");

  a_resp_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && stat.out_free) |=> state == S_IDLE)
    else $error("response did not finish the request");

  a_list_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_LRD) |=> state == S_LEM)
    else $error("list read not followed by emit");

endmodule
